// ===== hw/rtl/tfe_pkg.sv =====
// ----------------------------------------------------------------------------
// tfe_pkg
// shared types, framing constants and checksum helper for the telemetry
// frame encoder
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam logic [7:0] SOF_BYTE   = 8'h7E;
  localparam logic [7:0] EOF_BYTE   = 8'h0D;
  localparam logic [7:0] VER_SHORT  = 8'h90;
  localparam logic [7:0] VER_LONG   = 8'h91;
  localparam logic [7:0] CHK_ADJUST = 8'h30;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ADDR_IDX_W  = 3;
  localparam int unsigned ITEM_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDRESS = 1'd1;

  localparam logic [ADDR_IDX_W-1:0] ADDR_LAST_SHORT = 3'd3;
  localparam logic [ADDR_IDX_W-1:0] ADDR_LAST_LONG  = 3'd7;

  typedef enum logic [3:0] {
    PH_START,
    PH_SOF,
    PH_VER,
    PH_ADDR,
    PH_CID_HI,
    PH_CID_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CHK,
    PH_TERM
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic [15:0] cid;
  } item_t;

  typedef struct packed {
    logic       frame_end;
    logic       last_of_run;
    logic [7:0] out_byte;
  } obyte_t;

  function automatic logic [7:0] finish_checksum(input logic [7:0] x);
    logic [7:0] c;
    c = x + 8'd1;
    case (c) inside
      8'h00, 8'h7E, 8'h08, 8'h0A, 8'h0D, 8'h22: c = c + CHK_ADJUST;
      default: c = c;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/tfe_framer.sv =====
// ----------------------------------------------------------------------------
// tfe_framer
// byte sequencer: walks one held item through header, payload, checksum and
// terminator, one byte per advance, and keeps the running frame state
// ----------------------------------------------------------------------------
module tfe_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfe_pkg::item_t      item_i,
  input  logic                item_valid_i,
  input  logic                advance_i,
  input  logic                address_mode_i,
  input  logic [63:0]         station_address_i,
  output tfe_pkg::obyte_t     obyte_o
);

  tfe_pkg::phase_e                   phase_q, phase_d, cur_phase;
  logic [tfe_pkg::ADDR_IDX_W-1:0]    addr_idx_q, addr_idx_d;
  logic [15:0]                       bytes_left_q, bytes_left_d;
  logic                              in_frame_q, in_frame_d;
  logic [7:0]                        xor_q, xor_d;
  logic                              hdr_start;
  logic [15:0]                       bl_dec;
  logic [63:0]                       addr_shifted;

  assign hdr_start    = !in_frame_q || (bytes_left_q == 16'd0);
  assign bl_dec       = bytes_left_q - 16'd1;
  assign addr_shifted = station_address_i >> {addr_idx_q, 3'b000};

  always_comb begin
    cur_phase = phase_q;
    if (phase_q == tfe_pkg::PH_START) begin
      cur_phase = hdr_start ? tfe_pkg::PH_SOF : tfe_pkg::PH_DATA;
    end
  end

  // output byte
  always_comb begin
    obyte_o = '0;
    case (cur_phase)
      tfe_pkg::PH_SOF:    obyte_o.out_byte = tfe_pkg::SOF_BYTE;
      tfe_pkg::PH_VER:    obyte_o.out_byte = address_mode_i ? tfe_pkg::VER_LONG
                                                            : tfe_pkg::VER_SHORT;
      tfe_pkg::PH_ADDR:   obyte_o.out_byte = addr_shifted[7:0];
      tfe_pkg::PH_CID_HI: obyte_o.out_byte = item_i.cid[15:8];
      tfe_pkg::PH_CID_LO: obyte_o.out_byte = item_i.cid[7:0];
      tfe_pkg::PH_LEN_HI: obyte_o.out_byte = item_i.payload_length[15:8];
      tfe_pkg::PH_LEN_LO: obyte_o.out_byte = item_i.payload_length[7:0];
      tfe_pkg::PH_DATA: begin
        obyte_o.out_byte    = item_i.data_byte;
        obyte_o.last_of_run = (bl_dec != 16'd0);
      end
      tfe_pkg::PH_CHK:    obyte_o.out_byte = tfe_pkg::finish_checksum(xor_q);
      tfe_pkg::PH_TERM: begin
        obyte_o.out_byte    = tfe_pkg::EOF_BYTE;
        obyte_o.last_of_run = 1'b1;
        obyte_o.frame_end   = 1'b1;
      end
      default:            obyte_o = '0;
    endcase
  end

  // next phase
  always_comb begin
    phase_d    = phase_q;
    addr_idx_d = addr_idx_q;
    if (advance_i && item_valid_i) begin
      case (cur_phase)
        tfe_pkg::PH_SOF:    phase_d = tfe_pkg::PH_VER;
        tfe_pkg::PH_VER: begin
          phase_d    = tfe_pkg::PH_ADDR;
          addr_idx_d = address_mode_i ? tfe_pkg::ADDR_LAST_LONG : tfe_pkg::ADDR_LAST_SHORT;
        end
        tfe_pkg::PH_ADDR: begin
          if (addr_idx_q == '0) begin
            phase_d = tfe_pkg::PH_CID_HI;
          end else begin
            addr_idx_d = addr_idx_q - 1'b1;
          end
        end
        tfe_pkg::PH_CID_HI: phase_d = tfe_pkg::PH_CID_LO;
        tfe_pkg::PH_CID_LO: phase_d = tfe_pkg::PH_LEN_HI;
        tfe_pkg::PH_LEN_HI: phase_d = tfe_pkg::PH_LEN_LO;
        tfe_pkg::PH_LEN_LO: phase_d = (item_i.payload_length == 16'd0) ? tfe_pkg::PH_CHK
                                                                       : tfe_pkg::PH_DATA;
        tfe_pkg::PH_DATA:   phase_d = (bl_dec == 16'd0) ? tfe_pkg::PH_CHK
                                                        : tfe_pkg::PH_START;
        tfe_pkg::PH_CHK:    phase_d = tfe_pkg::PH_TERM;
        tfe_pkg::PH_TERM:   phase_d = tfe_pkg::PH_START;
        default:            phase_d = tfe_pkg::PH_START;
      endcase
    end
  end

  // frame state
  always_comb begin
    bytes_left_d = bytes_left_q;
    in_frame_d   = in_frame_q;
    xor_d        = xor_q;
    if (advance_i && item_valid_i) begin
      case (cur_phase)
        tfe_pkg::PH_VER: begin
          xor_d        = obyte_o.out_byte;
          bytes_left_d = item_i.payload_length;
          in_frame_d   = 1'b1;
        end
        tfe_pkg::PH_ADDR, tfe_pkg::PH_CID_HI, tfe_pkg::PH_CID_LO,
        tfe_pkg::PH_LEN_HI, tfe_pkg::PH_LEN_LO: begin
          xor_d = xor_q ^ obyte_o.out_byte;
        end
        tfe_pkg::PH_DATA: begin
          xor_d        = xor_q ^ obyte_o.out_byte;
          bytes_left_d = bl_dec;
        end
        tfe_pkg::PH_TERM: begin
          xor_d        = 8'h00;
          bytes_left_d = 16'd0;
          in_frame_d   = 1'b0;
        end
        default: begin
          xor_d = xor_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tfe_pkg::PH_START;
      addr_idx_q   <= '0;
      bytes_left_q <= 16'd0;
      in_frame_q   <= 1'b0;
      xor_q        <= 8'h00;
    end else begin
      phase_q      <= phase_d;
      addr_idx_q   <= addr_idx_d;
      bytes_left_q <= bytes_left_d;
      in_frame_q   <= in_frame_d;
      xor_q        <= xor_d;
    end
  end

endmodule

// ===== hw/rtl/telemetry_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_encoder_unit
// frames payload bytes into telemetry messages with header, checksum and
// terminator
// ----------------------------------------------------------------------------
// usage:
// - slave stream takes one payload byte per transfer together with cid and
//   payload_length; the first transfer of a frame supplies the header fields
// - master stream gives one encoded byte per transfer; tlast marks the last
//   byte caused by an input transfer, tuser marks the 0x0D terminator
// - config port writes address_mode (index 0) and station_address (index 1)
//   between frames; they apply from the next header
// - the first byte of an item passes through the item register, then the output register
// - throughput: one output byte per cycle while the receiver accepts; a payload item
//   yields one byte, a frame's first item 11 or 15 bytes, or 12 to 17 when it also
//   closes the frame, and a closing payload item two more for checksum and terminator
// - a new input transfer is taken in the cycle the held item's last byte
//   moves into the output register
// - when the receiver stalls the output register holds and the sequencer waits
// - reset clears the frame state and valids; address_mode resets to 1,
//   station_address to 0
// ----------------------------------------------------------------------------
module telemetry_frame_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cid[15:0], payload_length[31:16], data_byte[39:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // frame_end[0]
);

  logic            address_mode_q;
  logic [63:0]     station_address_q;
  tfe_pkg::item_t  item_q;
  logic            item_valid_q, item_valid_d;
  logic            out_valid_q, out_valid_d;
  tfe_pkg::obyte_t gen_byte;
  tfe_pkg::obyte_t out_q;
  logic            advance;
  logic            in_xfer;

  assign advance       = item_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !item_valid_q || (advance && gen_byte.last_of_run);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_mode_q    <= 1'b1;
      station_address_q <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfe_pkg::CFG_ADDRESS_MODE:    address_mode_q    <= cfg_wdata_i[0];
        tfe_pkg::CFG_STATION_ADDRESS: station_address_q <= cfg_wdata_i;
        default:                      address_mode_q    <= address_mode_q;
      endcase
    end
  end

  always_comb begin
    item_valid_d = item_valid_q;
    if (advance && gen_byte.last_of_run) begin
      item_valid_d = 1'b0;
    end
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= tfe_pkg::item_t'({s_axis_tdata[39:32], s_axis_tdata[31:16],
                                  s_axis_tdata[15:0]});
    end
    if (advance) begin
      out_q <= gen_byte;
    end
  end

  tfe_framer u_framer (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item_q),
    .item_valid_i      (item_valid_q),
    .advance_i         (advance),
    .address_mode_i    (address_mode_q),
    .station_address_i (station_address_q),
    .obyte_o           (gen_byte)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tlast  = out_q.last_of_run;
  assign m_axis_tuser  = out_q.frame_end;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("terminator byte not marked last");

  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == tfe_pkg::EOF_BYTE)
    else $error("terminator flag on wrong byte");

  a_ready_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !item_valid_q || advance)
    else $error("input ready while item slot busy");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("sequencer advance without output transfer pending");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for telemetry_frame_encoder_unit: payload items queued
// per configuration phase and streamed in with random gaps, each accepted
// item run through an in-bench frame encoder, each output transfer checked
// against the oldest queued byte with its tlast and tuser flags
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned QUIET_FROM   = 500;
  localparam int unsigned QUIET_TO     = 900;
  localparam int unsigned HOLD_AT      = 100;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned SETTLE       = 40;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_idx_i     = tfe_pkg::CFG_ADDRESS_MODE;
  logic [63:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // cid[15:0], payload_length[31:16], data_byte[39:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // out_byte[7:0]
  logic        m_axis_tlast;
  logic        m_axis_tuser;         // frame_end[0]

  tfe_pkg::item_t  pend_items[$];
  tfe_pkg::obyte_t expected_bytes[$];

  logic        mode_q    = 1'b1;
  logic [63:0] station_q = '0;
  logic        frame_open = 1'b0;
  logic [15:0] bytes_due  = '0;
  logic [7:0]  chk_xor    = '0;

  int unsigned cyc       = 0;
  int unsigned hold_left = 0;
  int          err_cnt   = 0;
  logic        noisy;

  telemetry_frame_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  assign noisy = !(cyc >= QUIET_FROM && cyc < QUIET_TO);

  // frame encoder
  task automatic put_byte(input logic [7:0] b, input logic fold, input logic fe);
    tfe_pkg::obyte_t ob;
    ob.out_byte    = b;
    ob.last_of_run = 1'b0;
    ob.frame_end   = fe;
    expected_bytes.push_back(ob);
    if (fold) chk_xor = chk_xor ^ b;
  endtask

  task automatic close_frame_bytes();
    logic [7:0] c;
    c = chk_xor + 8'd1;
    case (c)
      8'h00, tfe_pkg::SOF_BYTE, 8'h08, 8'h0A, tfe_pkg::EOF_BYTE, 8'h22:
        c = c + tfe_pkg::CHK_ADJUST;
      default: ;
    endcase
    put_byte(c, 1'b0, 1'b0);
    put_byte(tfe_pkg::EOF_BYTE, 1'b0, 1'b1);
    frame_open = 1'b0;
    bytes_due  = '0;
    chk_xor    = '0;
  endtask

  task automatic encode_item(input tfe_pkg::item_t it);
    tfe_pkg::obyte_t tail;
    int              nb;
    if (!frame_open || bytes_due == 16'd0) begin
      nb = mode_q ? 8 : 4;
      chk_xor = '0;
      put_byte(tfe_pkg::SOF_BYTE, 1'b0, 1'b0);
      put_byte(mode_q ? tfe_pkg::VER_LONG : tfe_pkg::VER_SHORT, 1'b1, 1'b0);
      for (int i = nb - 1; i >= 0; i--) put_byte(station_q[8*i +: 8], 1'b1, 1'b0);
      put_byte(it.cid[15:8], 1'b1, 1'b0);
      put_byte(it.cid[7:0], 1'b1, 1'b0);
      put_byte(it.payload_length[15:8], 1'b1, 1'b0);
      put_byte(it.payload_length[7:0], 1'b1, 1'b0);
      if (it.payload_length == 16'd0) begin
        close_frame_bytes();
      end else begin
        put_byte(it.data_byte, 1'b1, 1'b0);
        bytes_due  = it.payload_length - 16'd1;
        frame_open = 1'b1;
        if (bytes_due == 16'd0) close_frame_bytes();
      end
    end else begin
      put_byte(it.data_byte, 1'b1, 1'b0);
      bytes_due = bytes_due - 16'd1;
      if (bytes_due == 16'd0) close_frame_bytes();
    end
    tail = expected_bytes.pop_back();
    tail.last_of_run = 1'b1;
    expected_bytes.push_back(tail);
  endtask

  // stimulus helpers
  task automatic push_item(input logic [15:0] cid, input logic [15:0] len,
                           input logic [7:0] data);
    tfe_pkg::item_t it;
    it.cid            = cid;
    it.payload_length = len;
    it.data_byte      = data;
    pend_items.push_back(it);
  endtask

  task automatic push_frame(input int len);
    push_item(16'($urandom_range(65535)), 16'(len), 8'($urandom_range(255)));
    for (int i = 1; i < len; i++) begin
      push_item(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                8'($urandom_range(255)));
    end
  endtask

  task automatic random_frames(input int n);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 15) len = 0;
      else if (pick < 65) len = $urandom_range(4, 1);
      else if (pick < 95) len = $urandom_range(20, 5);
      else len = $urandom_range(64, 21);
      push_frame(len);
      sent += (len == 0) ? 1 : len;
    end
  endtask

  task automatic set_config(input logic mode, input logic [63:0] addr);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tfe_pkg::CFG_ADDRESS_MODE;
    cfg_wdata_i <= {junk[63:1], mode};
    @(posedge clk_i);
    cfg_idx_i   <= tfe_pkg::CFG_STATION_ADDRESS;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q    = mode;
    station_q = addr;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pend_items.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    tfe_pkg::item_t nxt;
    logic           go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) encode_item(tfe_pkg::item_t'(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        go = pend_items.size() != 0 && !(noisy && $urandom_range(99) < 27);
        if (go) begin
          nxt = pend_items.pop_front();
          s_axis_tdata <= nxt;
        end
        s_axis_tvalid <= go;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tfe_pkg::obyte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %02h last %b end %b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          err_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.out_byte) report("out_byte", want.out_byte, m_axis_tdata);
          if (m_axis_tlast !== want.last_of_run)
            report("last_of_run", 8'(want.last_of_run), 8'(m_axis_tlast));
          if (m_axis_tuser !== want.frame_end)
            report("frame_end", 8'(want.frame_end), 8'(m_axis_tuser));
        end
      end
      m_axis_tready <= (hold_left == 0) && !(noisy && $urandom_range(99) < 27);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (cyc == HOLD_AT) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] adj_vals [6];
    adj_vals = '{8'h00, tfe_pkg::SOF_BYTE, 8'h08, 8'h0A, tfe_pkg::EOF_BYTE, 8'h22};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: long form, address zero
    push_item(16'h0000, 16'h0000, 8'hFF);
    push_item(16'hFFFF, 16'h0001, 8'h00);
    push_item(16'h1234, 16'h0001, 8'hFF);
    push_item(16'h00FF, 16'h0002, 8'h7E);
    push_item(16'hFFFF, 16'hFFFF, 8'h0D);
    foreach (adj_vals[i]) begin
      push_item(16'h0000, 16'h0001,
                (adj_vals[i] - 8'd1) ^ tfe_pkg::VER_LONG ^ 8'h01);
    end
    push_frame(3);
    push_frame(30);
    drain();

    // short form, upper address bits set but not sent
    set_config(1'b0, '1);
    push_item(16'hFFFF, 16'h0000, 8'h00);
    push_item(16'h0000, 16'h0001, 8'hFF);
    random_frames(50);
    drain();

    set_config(1'b1, '1);
    random_frames(50);
    drain();
    set_config(1'b0, {$urandom, $urandom});
    random_frames(50);
    drain();
    set_config(1'b1, {$urandom, $urandom});
    random_frames(50);
    drain();
    set_config(1'b0, '0);
    random_frames(50);
    drain();
    set_config(1'b1, '0);
    random_frames(50);
    drain();

    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
